/* sv/rv32eu_pkg.sv */
// Package for the RV32 subset execute unit: word and index types, opcode,
// funct3 and funct7 codes shared by the channel interfaces and the RTL.
// No dependencies.
`default_nettype none

package rv32eu_pkg;

    localparam int XLEN     = 32;
    localparam int REG_W    = 5;
    localparam int NUM_REGS = 32;

    typedef logic [XLEN-1:0]  word_t;
    typedef logic [REG_W-1:0] reg_idx_t;
    typedef logic [6:0]       opcode_t;
    typedef logic [2:0]       funct3_t;
    typedef logic [6:0]       funct7_t;

    // Major opcodes.
    localparam opcode_t OP_LOAD   = 7'h03;
    localparam opcode_t OP_STORE  = 7'h23;
    localparam opcode_t OP_IMM    = 7'h13;
    localparam opcode_t OP_REG    = 7'h33;
    localparam opcode_t OP_LUI    = 7'h37;
    localparam opcode_t OP_AUIPC  = 7'h17;
    localparam opcode_t OP_JAL    = 7'h6F;
    localparam opcode_t OP_JALR   = 7'h67;
    localparam opcode_t OP_BRANCH = 7'h63;

    // Loads.
    localparam funct3_t F3_LB  = 3'd0;
    localparam funct3_t F3_LH  = 3'd1;
    localparam funct3_t F3_LW  = 3'd2;
    localparam funct3_t F3_LBU = 3'd4;
    localparam funct3_t F3_LHU = 3'd5;
    localparam funct3_t F3_LWX = 3'd6;

    // Stores.
    localparam funct3_t F3_SB = 3'd0;
    localparam funct3_t F3_SH = 3'd1;
    localparam funct3_t F3_SW = 3'd2;

    // Register and immediate ALU operations.
    localparam funct3_t F3_ADD = 3'd0;
    localparam funct3_t F3_XOR = 3'd4;
    localparam funct3_t F3_OR  = 3'd6;
    localparam funct3_t F3_AND = 3'd7;

    // Branches.
    localparam funct3_t F3_BEQ  = 3'd0;
    localparam funct3_t F3_BNE  = 3'd1;
    localparam funct3_t F3_BLT  = 3'd4;
    localparam funct3_t F3_BGE  = 3'd5;
    localparam funct3_t F3_BLTU = 3'd6;
    localparam funct3_t F3_BGEU = 3'd7;

    localparam funct7_t F7_BASE = 7'h00;
    localparam funct7_t F7_MUL  = 7'h01;
    localparam funct7_t F7_ALT  = 7'h20;

endpackage

`default_nettype wire

/* sv/rv32eu_if.sv */
// Valid/ready channel interfaces of the RV32 subset execute unit: the
// instruction issue channel and the result channel. Depends on rv32eu_pkg.
`default_nettype none

interface rv32eu_issue_if;
    logic                  valid;
    logic                  ready;
    rv32eu_pkg::word_t     instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface rv32eu_result_if;
    logic                  valid;
    logic                  ready;
    rv32eu_pkg::reg_idx_t  src1_index;
    rv32eu_pkg::word_t     src1_value;
    rv32eu_pkg::reg_idx_t  src2_index;
    rv32eu_pkg::word_t     src2_value;
    rv32eu_pkg::reg_idx_t  dest_index;
    rv32eu_pkg::word_t     dest_value;
    rv32eu_pkg::word_t     next_address;

    modport source (output valid, output src1_index, output src1_value,
                    output src2_index, output src2_value, output dest_index,
                    output dest_value, output next_address, input ready);
    modport sink   (input valid, input src1_index, input src1_value,
                    input src2_index, input src2_value, input dest_index,
                    input dest_value, input next_address, output ready);
endinterface

`default_nettype wire

/* sv/rv32eu_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// A read of the address written in the same cycle returns the new data.
// No dependencies.
`default_nettype none

module rv32eu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/rv32_subset_execute_unit_top.sv */
// Top level of the RV32 subset execute unit: two-stage execute pipeline,
// register file, program counter and byte-lane data memory.
// Depends on rv32eu_pkg, rv32eu_if (issue and result channels), rv32eu_ram.
//
// The unit executes one RV32 instruction per issue transfer and returns one
// result transfer for it, in order. Throughput is one instruction per clock
// while the result channel takes results and no clearing pass runs. The
// register file is read into the execute stage, which executes and reads data
// memory into the result stage; a result waits there while the result channel
// stalls. Operands are forwarded from the instruction ahead, including load
// data, so back-to-back dependent instructions do not stall. Data memory is
// four byte-wide RAMs of MEM_BYTES/4 rows; unaligned accesses wrap byte by
// byte. MEM_BYTES must be a power of two. After reset the memory is cleared
// one row per cycle; issue.ready stays low until that pass is done.
`default_nettype none

module rv32_subset_execute_unit_top #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rv32eu_issue_if.sink     issue,
    rv32eu_result_if.source  result
);

    localparam int MemAddrW = $clog2(MEM_BYTES);
    localparam int RowCount = MEM_BYTES / 4;
    localparam int RowW     = MemAddrW - 2;

    // Handshake.
    logic issue_xfer;
    logic result_xfer;
    logic s2_free;
    logic s1_adv;

    // Memory clearing pass.
    logic            clr_busy_reg;
    logic [RowW-1:0] clr_row_reg;

    // Register file.
    logic [rv32eu_pkg::NUM_REGS-1:0] rf_valid_reg;
    logic                            rf_we;
    rv32eu_pkg::reg_idx_t            rf_waddr;
    rv32eu_pkg::word_t               rf_wdata;
    rv32eu_pkg::reg_idx_t            in_rs1;
    rv32eu_pkg::reg_idx_t            in_rs2;
    rv32eu_pkg::reg_idx_t            in_rd;
    rv32eu_pkg::word_t               rf1_rdata;
    rv32eu_pkg::word_t               rf2_rdata;
    rv32eu_pkg::word_t               rfd_rdata;

    // Execute stage.
    logic                 s1_valid_reg;
    rv32eu_pkg::word_t    s1_instr_reg;
    logic                 s1_v1_reg;
    logic                 s1_v2_reg;
    logic                 s1_vd_reg;
    rv32eu_pkg::word_t    pc_reg;

    rv32eu_pkg::opcode_t  opcode;
    rv32eu_pkg::funct3_t  f3;
    rv32eu_pkg::funct7_t  f7;
    rv32eu_pkg::reg_idx_t rs1;
    rv32eu_pkg::reg_idx_t rs2;
    rv32eu_pkg::reg_idx_t rd;
    rv32eu_pkg::word_t    imm_i;
    rv32eu_pkg::word_t    imm_s;
    rv32eu_pkg::word_t    imm_b;
    rv32eu_pkg::word_t    imm_j;
    rv32eu_pkg::word_t    imm_u;
    rv32eu_pkg::word_t    op_a;
    rv32eu_pkg::word_t    op_b;
    rv32eu_pkg::word_t    rd_old;
    rv32eu_pkg::word_t    pc_plus4;
    rv32eu_pkg::word_t    sum_i;
    rv32eu_pkg::word_t    sum_s;
    rv32eu_pkg::word_t    mul_lo;
    logic                 lt_s;
    logic                 lt_u;
    logic                 take;
    logic                 s1_we_raw;
    logic                 s1_we;
    logic                 s1_is_load;
    logic                 s1_is_store;
    rv32eu_pkg::word_t    s1_result;
    rv32eu_pkg::word_t    s1_next;

    // Data memory lanes.
    logic [MemAddrW-1:0]  mem_addr;
    logic [1:0]           mem_off;
    logic [RowW-1:0]      mem_row;
    logic [1:0]           lane_k    [4];
    logic [RowW-1:0]      lane_row  [4];
    logic [7:0]           lane_wdata [4];
    logic                 lane_we   [4];
    logic                 lane_re;
    logic [7:0]           lane_rdata [4];
    logic [RowW-1:0]      lane_addr [4];
    logic [7:0]           lane_din  [4];

    // Result stage.
    logic                 s2_valid_reg;
    rv32eu_pkg::reg_idx_t s2_src1_index_reg;
    rv32eu_pkg::word_t    s2_src1_value_reg;
    rv32eu_pkg::reg_idx_t s2_src2_index_reg;
    rv32eu_pkg::word_t    s2_src2_value_reg;
    rv32eu_pkg::reg_idx_t s2_dest_index_reg;
    rv32eu_pkg::word_t    s2_rd_old_reg;
    logic                 s2_we_reg;
    logic                 s2_is_load_reg;
    rv32eu_pkg::funct3_t  s2_f3_reg;
    logic [1:0]           s2_off_reg;
    rv32eu_pkg::word_t    s2_alu_reg;
    rv32eu_pkg::word_t    s2_next_reg;
    logic [7:0]           ld_byte [4];
    rv32eu_pkg::word_t    ld_word;
    rv32eu_pkg::word_t    ld_value;
    rv32eu_pkg::word_t    s2_wdata;

    logic                 hit1;
    logic                 hit2;
    logic                 hitd;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign s2_free     = !s2_valid_reg || result.ready;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign issue.ready = !clr_busy_reg && (!s1_valid_reg || s2_free);
    assign issue_xfer  = issue.valid && issue.ready;
    assign result_xfer = result.valid && result.ready;

    // ------------------------------------------------------------------
    // Register file: three copies so rs1, rs2 and the old rd read at once
    // ------------------------------------------------------------------
    assign in_rs1 = issue.instruction[19:15];
    assign in_rs2 = issue.instruction[24:20];
    assign in_rd  = issue.instruction[11:7];

    assign rf_we    = result_xfer && s2_we_reg;
    assign rf_waddr = s2_dest_index_reg;
    assign rf_wdata = s2_wdata;

    rv32eu_ram #(
        .WIDTH (rv32eu_pkg::XLEN),
        .DEPTH (rv32eu_pkg::NUM_REGS)
    ) u_rf_rs1 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (issue_xfer),
        .raddr (in_rs1),
        .rdata (rf1_rdata)
    );

    rv32eu_ram #(
        .WIDTH (rv32eu_pkg::XLEN),
        .DEPTH (rv32eu_pkg::NUM_REGS)
    ) u_rf_rs2 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (issue_xfer),
        .raddr (in_rs2),
        .rdata (rf2_rdata)
    );

    rv32eu_ram #(
        .WIDTH (rv32eu_pkg::XLEN),
        .DEPTH (rv32eu_pkg::NUM_REGS)
    ) u_rf_rd (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (issue_xfer),
        .raddr (in_rd),
        .rdata (rfd_rdata)
    );

    // ------------------------------------------------------------------
    // Execute stage
    // ------------------------------------------------------------------
    assign opcode = s1_instr_reg[6:0];
    assign rd     = s1_instr_reg[11:7];
    assign f3     = s1_instr_reg[14:12];
    assign rs1    = s1_instr_reg[19:15];
    assign rs2    = s1_instr_reg[24:20];
    assign f7     = s1_instr_reg[31:25];

    assign imm_i = {{20{s1_instr_reg[31]}}, s1_instr_reg[31:20]};
    assign imm_s = {{20{s1_instr_reg[31]}}, s1_instr_reg[31:25], s1_instr_reg[11:7]};
    assign imm_b = {{20{s1_instr_reg[31]}}, s1_instr_reg[7], s1_instr_reg[30:25],
                    s1_instr_reg[11:8], 1'b0};
    assign imm_j = {{12{s1_instr_reg[31]}}, s1_instr_reg[19:12], s1_instr_reg[20],
                    s1_instr_reg[30:21], 1'b0};
    assign imm_u = {s1_instr_reg[31:12], 12'h000};

    // The instruction in the result stage has not written the register file
    // yet, so its result is forwarded. Writes to x0 never set s2_we_reg.
    assign hit1 = s2_valid_reg && s2_we_reg && (s2_dest_index_reg == rs1);
    assign hit2 = s2_valid_reg && s2_we_reg && (s2_dest_index_reg == rs2);
    assign hitd = s2_valid_reg && s2_we_reg && (s2_dest_index_reg == rd);

    assign op_a   = hit1 ? s2_wdata : (s1_v1_reg ? rf1_rdata : '0);
    assign op_b   = hit2 ? s2_wdata : (s1_v2_reg ? rf2_rdata : '0);
    assign rd_old = hitd ? s2_wdata : (s1_vd_reg ? rfd_rdata : '0);

    assign pc_plus4 = pc_reg + rv32eu_pkg::XLEN'(4);
    assign sum_i    = op_a + imm_i;
    assign sum_s    = op_a + imm_s;
    assign mul_lo   = op_a * op_b;
    assign lt_s     = $signed(op_a) < $signed(op_b);
    assign lt_u     = op_a < op_b;

    always_comb
    begin
        s1_we_raw   = 1'b0;
        s1_is_load  = 1'b0;
        s1_is_store = 1'b0;
        s1_result   = '0;
        s1_next     = pc_plus4;
        take        = 1'b0;
        unique case (opcode)
            rv32eu_pkg::OP_LOAD:
            begin
                unique case (f3) inside
                    rv32eu_pkg::F3_LB, rv32eu_pkg::F3_LH, rv32eu_pkg::F3_LW,
                    rv32eu_pkg::F3_LBU, rv32eu_pkg::F3_LHU, rv32eu_pkg::F3_LWX:
                    begin
                        s1_is_load = 1'b1;
                        s1_we_raw  = 1'b1;
                    end
                    default: ;
                endcase
            end
            rv32eu_pkg::OP_STORE:
            begin
                unique case (f3) inside
                    rv32eu_pkg::F3_SB, rv32eu_pkg::F3_SH, rv32eu_pkg::F3_SW:
                        s1_is_store = 1'b1;
                    default: ;
                endcase
            end
            rv32eu_pkg::OP_IMM:
            begin
                unique case (f3)
                    rv32eu_pkg::F3_ADD: begin s1_result = sum_i;         s1_we_raw = 1'b1; end
                    rv32eu_pkg::F3_XOR: begin s1_result = op_a ^ imm_i;  s1_we_raw = 1'b1; end
                    rv32eu_pkg::F3_OR:  begin s1_result = op_a | imm_i;  s1_we_raw = 1'b1; end
                    rv32eu_pkg::F3_AND: begin s1_result = op_a & imm_i;  s1_we_raw = 1'b1; end
                    default: ;
                endcase
            end
            rv32eu_pkg::OP_REG:
            begin
                unique case ({f7, f3})
                    {rv32eu_pkg::F7_BASE, rv32eu_pkg::F3_ADD}:
                    begin
                        s1_result = op_a + op_b;
                        s1_we_raw = 1'b1;
                    end
                    {rv32eu_pkg::F7_MUL, rv32eu_pkg::F3_ADD}:
                    begin
                        s1_result = mul_lo;
                        s1_we_raw = 1'b1;
                    end
                    {rv32eu_pkg::F7_ALT, rv32eu_pkg::F3_ADD}:
                    begin
                        s1_result = op_a - op_b;
                        s1_we_raw = 1'b1;
                    end
                    {rv32eu_pkg::F7_BASE, rv32eu_pkg::F3_XOR}:
                    begin
                        s1_result = op_a ^ op_b;
                        s1_we_raw = 1'b1;
                    end
                    {rv32eu_pkg::F7_BASE, rv32eu_pkg::F3_OR}:
                    begin
                        s1_result = op_a | op_b;
                        s1_we_raw = 1'b1;
                    end
                    {rv32eu_pkg::F7_BASE, rv32eu_pkg::F3_AND}:
                    begin
                        s1_result = op_a & op_b;
                        s1_we_raw = 1'b1;
                    end
                    default: ;
                endcase
            end
            rv32eu_pkg::OP_LUI:
            begin
                s1_result = imm_u;
                s1_we_raw = 1'b1;
            end
            rv32eu_pkg::OP_AUIPC:
            begin
                s1_result = pc_reg + imm_u;
                s1_we_raw = 1'b1;
            end
            rv32eu_pkg::OP_JAL:
            begin
                s1_result = pc_plus4;
                s1_we_raw = 1'b1;
                s1_next   = pc_reg + imm_j;
            end
            rv32eu_pkg::OP_JALR:
            begin
                s1_result = pc_plus4;
                s1_we_raw = 1'b1;
                s1_next   = {sum_i[rv32eu_pkg::XLEN-1:1], 1'b0};
            end
            rv32eu_pkg::OP_BRANCH:
            begin
                unique case (f3)
                    rv32eu_pkg::F3_BEQ:  take = (op_a == op_b);
                    rv32eu_pkg::F3_BNE:  take = (op_a != op_b);
                    rv32eu_pkg::F3_BLT:  take = lt_s;
                    rv32eu_pkg::F3_BGE:  take = !lt_s;
                    rv32eu_pkg::F3_BLTU: take = lt_u;
                    rv32eu_pkg::F3_BGEU: take = !lt_u;
                    default:             take = 1'b0;
                endcase
                if (take)
                begin
                    s1_next = pc_reg + imm_b;
                end
            end
            default: ;
        endcase
    end

    assign s1_we = s1_we_raw && (rd != '0);

    // ------------------------------------------------------------------
    // Data memory: byte k of an access lives in lane (offset + k) mod 4,
    // one row further on for lanes below the starting offset.
    // ------------------------------------------------------------------
    assign mem_addr = s1_is_store ? sum_s[MemAddrW-1:0] : sum_i[MemAddrW-1:0];
    assign mem_off  = mem_addr[1:0];
    assign mem_row  = mem_addr[MemAddrW-1:2];
    assign lane_re  = s1_adv && s1_is_load;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            lane_k[l]     = 2'(l) - mem_off;
            lane_row[l]   = (2'(l) < mem_off) ? mem_row + RowW'(1) : mem_row;
            lane_wdata[l] = op_b[{lane_k[l], 3'b000} +: 8];
            lane_we[l]    = 1'b0;
            if (s1_adv && s1_is_store)
            begin
                case (f3)
                    rv32eu_pkg::F3_SB: lane_we[l] = (lane_k[l] == 2'd0);
                    rv32eu_pkg::F3_SH: lane_we[l] = !lane_k[l][1];
                    default:           lane_we[l] = 1'b1;
                endcase
            end
            if (clr_busy_reg)
            begin
                lane_addr[l] = clr_row_reg;
                lane_din[l]  = 8'h00;
                lane_we[l]   = 1'b1;
            end
            else
            begin
                lane_addr[l] = lane_row[l];
                lane_din[l]  = lane_wdata[l];
            end
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        rv32eu_ram #(
            .WIDTH (8),
            .DEPTH (RowCount)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we[g]),
            .waddr (lane_addr[g]),
            .wdata (lane_din[g]),
            .re    (lane_re),
            .raddr (lane_addr[g]),
            .rdata (lane_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // Result stage: load alignment and extension
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ld_byte[k] = lane_rdata[2'(k) + s2_off_reg];
        end
    end

    assign ld_word = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};

    always_comb
    begin
        case (s2_f3_reg)
            rv32eu_pkg::F3_LB:  ld_value = {{24{ld_word[7]}}, ld_word[7:0]};
            rv32eu_pkg::F3_LH:  ld_value = {{16{ld_word[15]}}, ld_word[15:0]};
            rv32eu_pkg::F3_LBU: ld_value = {24'h000000, ld_word[7:0]};
            rv32eu_pkg::F3_LHU: ld_value = {16'h0000, ld_word[15:0]};
            default:            ld_value = ld_word;
        endcase
    end

    assign s2_wdata = s2_is_load_reg ? ld_value : s2_alu_reg;

    assign result.valid        = s2_valid_reg;
    assign result.src1_index   = s2_src1_index_reg;
    assign result.src1_value   = s2_src1_value_reg;
    assign result.src2_index   = s2_src2_index_reg;
    assign result.src2_value   = s2_src2_value_reg;
    assign result.dest_index   = s2_dest_index_reg;
    assign result.dest_value   = s2_we_reg ? s2_wdata : s2_rd_old_reg;
    assign result.next_address = s2_next_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= '0;
            rf_valid_reg <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_row_reg == RowW'(RowCount - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_row_reg <= clr_row_reg + RowW'(1);
            end

            if (issue_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                pc_reg       <= s1_next;
            end
            else if (result_xfer)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (issue_xfer)
        begin
            s1_instr_reg <= issue.instruction;
            // A register written in this same cycle counts as written.
            s1_v1_reg    <= rf_valid_reg[in_rs1] || (rf_we && (rf_waddr == in_rs1));
            s1_v2_reg    <= rf_valid_reg[in_rs2] || (rf_we && (rf_waddr == in_rs2));
            s1_vd_reg    <= rf_valid_reg[in_rd] || (rf_we && (rf_waddr == in_rd));
        end
        if (s1_adv)
        begin
            s2_src1_index_reg <= rs1;
            s2_src1_value_reg <= op_a;
            s2_src2_index_reg <= rs2;
            s2_src2_value_reg <= op_b;
            s2_dest_index_reg <= rd;
            s2_rd_old_reg     <= rd_old;
            s2_we_reg         <= s1_we;
            s2_is_load_reg    <= s1_is_load;
            s2_f3_reg         <= f3;
            s2_off_reg        <= mem_off;
            s2_alu_reg        <= s1_result;
            s2_next_reg       <= s1_next;
        end
    end

endmodule

`default_nettype wire
